// File: hdl/uhsc_pkg.sv
// Shared types, constants and the Han code point test for the UTF-16 Han string checker.
`default_nettype none

package uhsc_pkg;

	localparam int unsigned UnitWidth = 32;
	localparam int unsigned OffsetWidth = 10;

	localparam logic [UnitWidth-1:0] HanIdeoZero = 32'h0000_3007;
	localparam logic [UnitWidth-1:0] HanExtALo = 32'h0000_3400;
	localparam logic [UnitWidth-1:0] HanExtAHi = 32'h0000_4DBF;
	localparam logic [UnitWidth-1:0] HanUniLo = 32'h0000_4E00;
	localparam logic [UnitWidth-1:0] HanUniHi = 32'h0000_9FFF;
	localparam logic [UnitWidth-1:0] HanCompatLo = 32'h0000_F900;
	localparam logic [UnitWidth-1:0] HanCompatHi = 32'h0000_FAFF;
	localparam logic [UnitWidth-1:0] HanSipLo = 32'h0002_0000;
	localparam logic [UnitWidth-1:0] HanSipHi = 32'h0002_FA1F;
	localparam logic [UnitWidth-1:0] HanTipLo = 32'h0003_0000;
	localparam logic [UnitWidth-1:0] HanTipHi = 32'h0003_347F;

	localparam logic [5:0] HighSurrTag = 6'b110110;
	localparam logic [5:0] LowSurrTag = 6'b110111;
	localparam logic [UnitWidth-1:0] SuppBase = 32'h0001_0000;

	localparam logic SurrogateModeReset = 1'b1;

	typedef struct packed {
		logic pending_high;
		logic [OffsetWidth-1:0] high_offset;
		logic failed;
		logic saw_unit;
	} uhsc_state_t;

	localparam uhsc_state_t StateClear = '{
		pending_high: 1'b0,
		high_offset: '0,
		failed: 1'b0,
		saw_unit: 1'b0
	};

	function automatic logic han_point(input logic [UnitWidth-1:0] cp);
		han_point = cp inside {HanIdeoZero, [HanExtALo:HanExtAHi], [HanUniLo:HanUniHi],
			[HanCompatLo:HanCompatHi], [HanSipLo:HanSipHi], [HanTipLo:HanTipHi]};
	endfunction

endpackage

`default_nettype wire

// File: hdl/uhsc_step.sv
// Combinational next-state and verdict logic for one code unit item.
`default_nettype none

module uhsc_step (
	input  wire logic                          surrogate_mode,
	input  wire uhsc_pkg::uhsc_state_t         cur,
	input  wire logic [uhsc_pkg::UnitWidth-1:0] code_unit,
	input  wire logic                          carries_unit,
	input  wire logic                          last,
	output uhsc_pkg::uhsc_state_t              nxt,
	output logic                               is_han
);
	import uhsc_pkg::*;

	logic [15:0] u16;
	logic is_high;
	logic is_low;
	logic [UnitWidth-1:0] pair_cp;
	uhsc_state_t upd;

	assign u16 = code_unit[15:0];
	assign is_high = (u16[15:10] == HighSurrTag);
	assign is_low = (u16[15:10] == LowSurrTag);
	assign pair_cp = SuppBase + {{(UnitWidth-2*OffsetWidth){1'b0}}, cur.high_offset, u16[9:0]};

	always_comb begin
		upd = cur;
		if (carries_unit) begin
			upd.saw_unit = 1'b1;
			if (surrogate_mode) begin
				if (cur.pending_high) begin
					upd.pending_high = 1'b0;
					upd.high_offset = '0;
					if (!is_low || !han_point(pair_cp)) begin
						upd.failed = 1'b1;
					end
				end else if (is_high) begin
					upd.pending_high = 1'b1;
					upd.high_offset = u16[9:0];
				end else if (is_low || !han_point({16'h0000, u16})) begin
					upd.failed = 1'b1;
				end
			end else begin
				if (cur.pending_high) begin
					upd.pending_high = 1'b0;
					upd.high_offset = '0;
					upd.failed = 1'b1;
				end
				if (!han_point(code_unit)) begin
					upd.failed = 1'b1;
				end
			end
		end
	end

	assign is_han = !upd.failed && upd.saw_unit && !upd.pending_high;
	assign nxt = last ? StateClear : upd;

endmodule

`default_nettype wire

// File: hdl/utf16_han_string_checker.sv
// Top level of the UTF-16 Han string checker: input register, string state and verdict register.
//
// A string arrives as a sequence of items on the input channel (in_valid, in_stall),
// one code unit per item, with last set on its final item. An item with carries_unit
// low and last high ends the string without a unit; an item with both low is ignored.
// One verdict item (is_han) leaves on the output channel (out_valid, out_stall) for
// each item marked last, and none for any other item.
// An item passes an input register, then the decode and range logic updates the string
// state and, on a last item, loads the verdict register. A last item waits in the input
// register until the verdict register is free. One item is accepted every cycle while
// in_stall is low; the single verdict register and the input register set this figure.
// When the receiver stalls with a verdict waiting, items that do not end a string keep
// flowing; an item that ends a string waits in the input register and in_stall rises.
// The mode register (cfg_we, cfg_wdata) selects surrogate decoding when set; the user must
// write it only while no item is in flight, as the block itself does not enforce this.
// Reset sets the mode to surrogate decoding, clears the string state and empties
// both registers; in_stall is low once reset is released, so items can be accepted.
`default_nettype none

module utf16_han_string_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [uhsc_pkg::UnitWidth-1:0] code_unit,
	input  wire logic                           carries_unit,
	input  wire logic                           last,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                is_han
);
	import uhsc_pkg::*;

	logic mode_q;
	logic valid_s1;
	logic [UnitWidth-1:0] code_unit_s1;
	logic carries_unit_s1;
	logic last_s1;
	uhsc_state_t state_q;
	uhsc_state_t state_nxt;
	logic verdict;
	logic out_valid_q;
	logic is_han_q;
	logic out_free;
	logic s1_go;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_go = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !s1_go;

	uhsc_step u_step (
		.surrogate_mode(mode_q),
		.cur(state_q),
		.code_unit(code_unit_s1),
		.carries_unit(carries_unit_s1),
		.last(last_s1),
		.nxt(state_nxt),
		.is_han(verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= SurrogateModeReset;
			valid_s1 <= 1'b0;
			state_q <= StateClear;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (s1_go) begin
				state_q <= state_nxt;
			end
			if (s1_go && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			code_unit_s1 <= code_unit;
			carries_unit_s1 <= carries_unit;
			last_s1 <= last;
		end
		if (s1_go && last_s1) begin
			is_han_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign is_han = is_han_q;

endmodule

`default_nettype wire
